>>> src/tsh_pkg.sv
`default_nettype none

package tsh_pkg;

   // Lanes carried on the ports; only the first NUM_VALUES take part in the sort.
   localparam int LANES       = 8;
   localparam int NUM_VALUES  = 8;
   localparam int SAMPLE_W    = 24;
   localparam int QUEUE_DEPTH = 2;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef sample_type lanes_type [LANES];

   // One classified beat handed from the front to the back.
   typedef struct {
      logic      fire;
      lanes_type value;
   } entry_type;

   // One layer of an odd-even transposition network: compare-exchange the
   // neighbor pairs whose lower index has the given parity.
   function automatic lanes_type sort_layer(lanes_type d, logic phase);
      lanes_type r;
      r = d;
      for (int i = 0; i < LANES - 1; i++) begin
         if ((i + 1 < NUM_VALUES) && (i[0] == phase)) begin
            if (d[i] > d[i+1]) begin
               r[i]   = d[i+1];
               r[i+1] = d[i];
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> src/tsh_front.sv
`default_nettype none

module tsh_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire tsh_pkg::sample_type req_trigger,
   input  wire tsh_pkg::lanes_type  req_values,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output tsh_pkg::entry_type       push_entry
);

   logic was_pos_ff;
   logic was_pos_in;
   logic positive;
   logic accept;

   assign positive   = (req_trigger > 0);
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Fire on a rising edge above zero; drop lanes beyond the sort width.
   always_comb begin
      push_entry.fire = positive && !was_pos_ff;
      for (int i = 0; i < tsh_pkg::LANES; i++) begin
         push_entry.value[i] = (i < tsh_pkg::NUM_VALUES) ? req_values[i] : '0;
      end
   end

   assign was_pos_in = accept ? positive : was_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pos_ff <= 1'b0;
      end else begin
         was_pos_ff <= was_pos_in;
      end
   end

endmodule

`default_nettype wire

>>> src/tsh_queue.sv
`default_nettype none

module tsh_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire tsh_pkg::entry_type push_entry,
   output logic                    pop_valid,
   input  wire logic               pop,
   output tsh_pkg::entry_type      pop_entry
);

   localparam int PTR_W = (tsh_pkg::QUEUE_DEPTH > 1) ? $clog2(tsh_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(tsh_pkg::QUEUE_DEPTH + 1);

   tsh_pkg::entry_type mem_ff [tsh_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != CNT_W'(tsh_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tsh_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tsh_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(tsh_pkg::QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |=> (count_ff <= CNT_W'(1)))
      else $error("queue filled by more than one beat from empty");

endmodule

`default_nettype wire

>>> src/tsh_back.sv
`default_nettype none

module tsh_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   output logic                    q_pop,
   input  wire tsh_pkg::entry_type q_entry,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output tsh_pkg::lanes_type      held
);

   localparam int STAGES = tsh_pkg::NUM_VALUES;
   localparam int LAST   = STAGES - 1;

   logic               advance;
   logic               valid_ff [STAGES];
   logic               fire_ff  [STAGES];
   tsh_pkg::lanes_type data_ff  [STAGES];
   tsh_pkg::lanes_type data_in  [STAGES];
   logic               rsp_valid_ff;
   tsh_pkg::lanes_type held_ff;
   logic               held_order_ok;
   logic [tsh_pkg::LANES*tsh_pkg::SAMPLE_W-1:0] held_flat;

   // Whole network moves together; it stalls only when the result is stuck.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign q_pop     = q_valid && advance;
   assign rsp_valid = rsp_valid_ff;
   assign held      = held_ff;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam logic PHASE = 1'(s % 2);
      if (s == 0) begin : g_first
         assign data_in[s] = tsh_pkg::sort_layer(q_entry.value, PHASE);
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= q_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               fire_ff[s] <= q_entry.fire;
               data_ff[s] <= data_in[s];
            end
         end
      end else begin : g_rest
         assign data_in[s] = tsh_pkg::sort_layer(data_ff[s-1], PHASE);
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (advance) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               fire_ff[s] <= fire_ff[s-1];
               data_ff[s] <= data_in[s];
            end
         end
      end
   end

   // Capture the sorted set on a fire beat, otherwise hold the previous one.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         held_ff      <= '{default: '0};
      end else if (advance) begin
         rsp_valid_ff <= valid_ff[LAST];
         if (valid_ff[LAST] && fire_ff[LAST]) begin
            held_ff <= data_ff[LAST];
         end
      end
   end

   always_comb begin
      held_order_ok = 1'b1;
      for (int i = 0; i < tsh_pkg::NUM_VALUES - 1; i++) begin
         if (held_ff[i] > held_ff[i+1]) begin
            held_order_ok = 1'b0;
         end
      end
      for (int i = 0; i < tsh_pkg::LANES; i++) begin
         held_flat[i*tsh_pkg::SAMPLE_W +: tsh_pkg::SAMPLE_W] = held_ff[i];
      end
   end

   a_held_sorted: assert property (@(posedge clock) disable iff (reset)
      held_order_ok)
      else $error("held values not in ascending order");

   a_hold_without_fire: assert property (@(posedge clock) disable iff (reset)
      !(advance && valid_ff[LAST] && fire_ff[LAST]) |=> $stable(held_flat))
      else $error("held values changed without a fire beat");

   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(valid_ff[LAST]))
      else $error("result raised without a beat leaving the network");

endmodule

`default_nettype wire

>>> src/triggered_sort_and_hold_unit.sv
`default_nettype none

// Triggered sort-and-hold.
// Input channel (req_*): one beat per sample tick, carrying a signed 24-bit
// trigger and eight signed 24-bit values. A beat moves when req_valid and
// req_ready are both high at a rising clock edge.
// Result channel (rsp_*): exactly one beat per input beat, in order, carrying
// the eight held values sorted ascending (rsp_sorted_0 is the smallest).
// A beat whose trigger is above zero while the previous beat's trigger was at
// or below zero captures its values; all other beats repeat the held set.
// From accept to rsp_valid, the queue entry feeds the first layer of the
// odd-even transposition network, each layer is registered, and the result
// then passes through the output register.
// Throughput: one beat per cycle while the receiver does not stall the result.
// Reset (synchronous, active high): held values clear to zero, the trigger
// history clears to "not positive", queue and pipeline empty.
// Receiver stall: the network and output register hold; the two-entry queue
// absorbs the beats in flight and req_ready drops once it is full.
module triggered_sort_and_hold_unit (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [23:0]  req_trigger,
   input  wire logic signed [23:0]  req_value_0,
   input  wire logic signed [23:0]  req_value_1,
   input  wire logic signed [23:0]  req_value_2,
   input  wire logic signed [23:0]  req_value_3,
   input  wire logic signed [23:0]  req_value_4,
   input  wire logic signed [23:0]  req_value_5,
   input  wire logic signed [23:0]  req_value_6,
   input  wire logic signed [23:0]  req_value_7,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [23:0]       rsp_sorted_0,
   output logic signed [23:0]       rsp_sorted_1,
   output logic signed [23:0]       rsp_sorted_2,
   output logic signed [23:0]       rsp_sorted_3,
   output logic signed [23:0]       rsp_sorted_4,
   output logic signed [23:0]       rsp_sorted_5,
   output logic signed [23:0]       rsp_sorted_6,
   output logic signed [23:0]       rsp_sorted_7
);

   tsh_pkg::lanes_type req_values;
   tsh_pkg::lanes_type held;
   tsh_pkg::entry_type push_entry;
   tsh_pkg::entry_type pop_entry;
   logic               push_valid;
   logic               push_ready;
   logic               pop_valid;
   logic               pop;

   // Gather the value lanes into one array.
   assign req_values[0] = req_value_0;
   assign req_values[1] = req_value_1;
   assign req_values[2] = req_value_2;
   assign req_values[3] = req_value_3;
   assign req_values[4] = req_value_4;
   assign req_values[5] = req_value_5;
   assign req_values[6] = req_value_6;
   assign req_values[7] = req_value_7;

   // Front: detect the rising trigger and tag the beat.
   tsh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_trigger(req_trigger),
      .req_values (req_values),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Short queue decoupling the front from the sorting back end.
   tsh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   // Back: pipelined sorting network plus the hold register.
   tsh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_pop      (pop),
      .q_entry    (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .held       (held)
   );

   // Spread the held set onto the result ports.
   assign rsp_sorted_0 = held[0];
   assign rsp_sorted_1 = held[1];
   assign rsp_sorted_2 = held[2];
   assign rsp_sorted_3 = held[3];
   assign rsp_sorted_4 = held[4];
   assign rsp_sorted_5 = held[5];
   assign rsp_sorted_6 = held[6];
   assign rsp_sorted_7 = held[7];

endmodule

`default_nettype wire
